// ===== rtl/core/ftbgf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ftbgf_pkg
// Shared types and constants of the force/torque gravity compensation filter.
// ----------------------------------------------------------------------------
package ftbgf_pkg;

    localparam int BIAS_SAMPLES = 64;
    localparam int CNT_W        = 7;
    localparam int LANE_W       = 3;
    localparam int LANES        = 6;

    localparam int WR_W   = 24;   // wrench sample and filter width
    localparam int Q_W    = 16;   // quaternion component width
    localparam int SUM_W  = 32;   // bias sum width
    localparam int A_W    = 36;   // multiplier operand a
    localparam int B_W    = 21;   // multiplier operand b
    localparam int P_W    = A_W + B_W;
    localparam int T_W    = 44;   // partial result register
    localparam int R_W    = 21;   // rounded rotation row entry
    localparam int MG_W   = 35;   // load mass times gravity
    localparam int LD_W   = 31;   // load wrench entry
    localparam int CIDX_W = 3;
    localparam int CDAT_W = 16;

    localparam logic signed [A_W-1:0] GRAV_Q16 = A_W'(2632453);

    typedef enum logic [CIDX_W-1:0] {
        REG_FILTER_GAIN   = 3'd0,
        REG_LOAD_MASS     = 3'd1,
        REG_LOAD_OFFSET_X = 3'd2,
        REG_LOAD_OFFSET_Y = 3'd3,
        REG_LOAD_OFFSET_Z = 3'd4
    } reg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_MG,
        ST_Q0, ST_Q1, ST_Q2, ST_Q3, ST_Q4, ST_Q5, ST_Q6, ST_Q7,
        ST_F0, ST_F1, ST_F2, ST_FW,
        ST_T0A, ST_T0B, ST_T1A, ST_T1B, ST_T2A, ST_T2B, ST_TE,
        ST_BIAS,
        ST_AVG,
        ST_FA, ST_FB, ST_FC,
        ST_DONE
    } state_t;

    typedef struct packed {
        state_t            step;
        logic [LANE_W-1:0] lane;
        logic              capture;
        logic              publish;
        logic              calibrated;
    } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/core/ftbgf_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ftbgf_ctrl
// Sequencer: steps the shared multiplier, counts bias samples, owns handshakes.
// ----------------------------------------------------------------------------
module ftbgf_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  wire logic           pose_valid,
    output logic                out_valid,
    input  wire logic           out_ready,
    output ftbgf_pkg::cmd_t     cmd
);

    ftbgf_pkg::state_t                 state_reg, state_next;
    logic [ftbgf_pkg::CNT_W-1:0]       count_reg, count_next;
    logic [ftbgf_pkg::LANE_W-1:0]      lane_reg, lane_next;
    logic                              calib_reg, calib_next;
    logic                              out_valid_reg, out_valid_next;
    logic                              publish;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ftbgf_pkg::ST_IDLE;
            count_reg     <= '0;
            lane_reg      <= '0;
            calib_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            lane_reg      <= lane_next;
            calib_reg     <= calib_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        lane_next  = lane_reg;
        calib_next = calib_reg;
        publish    = 1'b0;
        unique case (state_reg)
            ftbgf_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = pose_valid ? ftbgf_pkg::ST_MG : ftbgf_pkg::ST_DONE;
            end
            ftbgf_pkg::ST_MG:  state_next = ftbgf_pkg::ST_Q0;
            ftbgf_pkg::ST_Q0:  state_next = ftbgf_pkg::ST_Q1;
            ftbgf_pkg::ST_Q1:  state_next = ftbgf_pkg::ST_Q2;
            ftbgf_pkg::ST_Q2:  state_next = ftbgf_pkg::ST_Q3;
            ftbgf_pkg::ST_Q3:  state_next = ftbgf_pkg::ST_Q4;
            ftbgf_pkg::ST_Q4:  state_next = ftbgf_pkg::ST_Q5;
            ftbgf_pkg::ST_Q5:  state_next = ftbgf_pkg::ST_Q6;
            ftbgf_pkg::ST_Q6:  state_next = ftbgf_pkg::ST_Q7;
            ftbgf_pkg::ST_Q7:  state_next = ftbgf_pkg::ST_F0;
            ftbgf_pkg::ST_F0:  state_next = ftbgf_pkg::ST_F1;
            ftbgf_pkg::ST_F1:  state_next = ftbgf_pkg::ST_F2;
            ftbgf_pkg::ST_F2:  state_next = ftbgf_pkg::ST_FW;
            ftbgf_pkg::ST_FW:  state_next = ftbgf_pkg::ST_T0A;
            ftbgf_pkg::ST_T0A: state_next = ftbgf_pkg::ST_T0B;
            ftbgf_pkg::ST_T0B: state_next = ftbgf_pkg::ST_T1A;
            ftbgf_pkg::ST_T1A: state_next = ftbgf_pkg::ST_T1B;
            ftbgf_pkg::ST_T1B: state_next = ftbgf_pkg::ST_T2A;
            ftbgf_pkg::ST_T2A: state_next = ftbgf_pkg::ST_T2B;
            ftbgf_pkg::ST_T2B: state_next = ftbgf_pkg::ST_TE;
            ftbgf_pkg::ST_TE:
            begin
                lane_next  = '0;
                state_next = calib_reg ? ftbgf_pkg::ST_FA : ftbgf_pkg::ST_BIAS;
            end
            ftbgf_pkg::ST_BIAS:
            begin
                count_next = count_reg + ftbgf_pkg::CNT_W'(1);
                if (count_next == ftbgf_pkg::CNT_W'(ftbgf_pkg::BIAS_SAMPLES))
                    state_next = ftbgf_pkg::ST_AVG;
                else
                    state_next = ftbgf_pkg::ST_DONE;
            end
            ftbgf_pkg::ST_AVG:
            begin
                calib_next = 1'b1;
                state_next = ftbgf_pkg::ST_FA;
            end
            ftbgf_pkg::ST_FA:  state_next = ftbgf_pkg::ST_FB;
            ftbgf_pkg::ST_FB:  state_next = ftbgf_pkg::ST_FC;
            ftbgf_pkg::ST_FC:
            begin
                if (lane_reg == ftbgf_pkg::LANE_W'(ftbgf_pkg::LANES - 1))
                    state_next = ftbgf_pkg::ST_DONE;
                else
                begin
                    lane_next  = lane_reg + ftbgf_pkg::LANE_W'(1);
                    state_next = ftbgf_pkg::ST_FA;
                end
            end
            ftbgf_pkg::ST_DONE:
            begin
                // The result register may still hold the previous beat.
                if (!out_valid_reg || out_ready)
                begin
                    publish    = 1'b1;
                    state_next = ftbgf_pkg::ST_IDLE;
                end
            end
            default: state_next = ftbgf_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_ready)
            out_valid_next = 1'b0;
        if (publish)
            out_valid_next = 1'b1;
    end

    assign in_ready       = (state_reg == ftbgf_pkg::ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign cmd.step       = state_reg;
    assign cmd.lane       = lane_reg;
    assign cmd.capture    = in_valid && (state_reg == ftbgf_pkg::ST_IDLE);
    assign cmd.publish    = publish;
    assign cmd.calibrated = calib_reg;

endmodule
`default_nettype wire

// ===== rtl/core/ftbgf_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// ftbgf_dp
// Datapath: configuration, one shared multiplier, load, bias and filter state.
// ----------------------------------------------------------------------------
module ftbgf_dp (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire ftbgf_pkg::cmd_t                   cmd,
    input  wire logic                              cfg_we,
    input  wire logic [ftbgf_pkg::CIDX_W-1:0]      cfg_index,
    input  wire logic [ftbgf_pkg::CDAT_W-1:0]      cfg_data,
    input  wire logic signed [ftbgf_pkg::WR_W-1:0] raw_in [ftbgf_pkg::LANES],
    input  wire logic signed [ftbgf_pkg::Q_W-1:0]  quat_w,
    input  wire logic signed [ftbgf_pkg::Q_W-1:0]  quat_x,
    input  wire logic signed [ftbgf_pkg::Q_W-1:0]  quat_y,
    input  wire logic signed [ftbgf_pkg::Q_W-1:0]  quat_z,
    output logic signed [ftbgf_pkg::WR_W-1:0]      filt_out [ftbgf_pkg::LANES],
    output logic                                   cal_out
);

    function automatic logic signed [ftbgf_pkg::P_W-1:0] rnd_shift(
        input logic signed [ftbgf_pkg::P_W-1:0] v,
        input int unsigned                      sh
    );
        logic signed [ftbgf_pkg::P_W-1:0] half;
        half = ftbgf_pkg::P_W'(1) <<< (sh - 1);
        return (v + half) >>> sh;
    endfunction

    logic [15:0]                              gain_reg;
    logic [11:0]                              mass_reg;
    logic signed [15:0]                       ofs_x_reg, ofs_y_reg, ofs_z_reg;

    logic signed [ftbgf_pkg::WR_W-1:0]        raw_reg [ftbgf_pkg::LANES];
    logic signed [ftbgf_pkg::Q_W-1:0]         qw_reg, qx_reg, qy_reg, qz_reg;
    logic signed [ftbgf_pkg::P_W-1:0]         p_reg;
    logic signed [ftbgf_pkg::T_W-1:0]         t_reg;
    logic signed [ftbgf_pkg::MG_W-1:0]        mg_reg;
    logic signed [ftbgf_pkg::R_W-1:0]         r0_reg, r1_reg, r2_reg;
    logic signed [ftbgf_pkg::LD_W-1:0]        ld_reg [ftbgf_pkg::LANES];
    logic signed [ftbgf_pkg::SUM_W-1:0]       bias_reg [ftbgf_pkg::LANES];
    logic signed [ftbgf_pkg::WR_W-1:0]        filt_reg [ftbgf_pkg::LANES];
    logic signed [ftbgf_pkg::WR_W-1:0]        out_filt_reg [ftbgf_pkg::LANES];
    logic                                     out_cal_reg;

    logic signed [ftbgf_pkg::A_W-1:0]         mul_a;
    logic signed [ftbgf_pkg::B_W-1:0]         mul_b;
    logic signed [ftbgf_pkg::P_W-1:0]         t_ext, sum_add, sum_sub, filt_rnd;
    logic signed [ftbgf_pkg::A_W-1:0]         w_lane;
    logic [16:0]                              gain_inv;

    assign t_ext    = ftbgf_pkg::P_W'(t_reg);
    assign sum_add  = t_ext + p_reg;
    assign sum_sub  = t_ext - p_reg;
    assign filt_rnd = rnd_shift(sum_add, 16);
    assign gain_inv = 17'h10000 - {1'b0, gain_reg};
    assign w_lane   = ftbgf_pkg::A_W'(raw_reg[cmd.lane])
                    - ftbgf_pkg::A_W'(bias_reg[cmd.lane])
                    - ftbgf_pkg::A_W'(ld_reg[cmd.lane]);

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= 16'd0;
            mass_reg  <= 12'd100;
            ofs_x_reg <= 16'sd0;
            ofs_y_reg <= 16'sd0;
            ofs_z_reg <= 16'sd143;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ftbgf_pkg::REG_FILTER_GAIN:   gain_reg  <= cfg_data;
                ftbgf_pkg::REG_LOAD_MASS:     mass_reg  <= cfg_data[11:0];
                ftbgf_pkg::REG_LOAD_OFFSET_X: ofs_x_reg <= $signed(cfg_data);
                ftbgf_pkg::REG_LOAD_OFFSET_Y: ofs_y_reg <= $signed(cfg_data);
                ftbgf_pkg::REG_LOAD_OFFSET_Z: ofs_z_reg <= $signed(cfg_data);
                default: ;
            endcase
        end
    end

    // Operand selection for the shared multiplier.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.step)
            ftbgf_pkg::ST_MG:
            begin
                mul_a = ftbgf_pkg::GRAV_Q16;
                mul_b = $signed({9'd0, mass_reg});
            end
            ftbgf_pkg::ST_Q0:
            begin
                mul_a = ftbgf_pkg::A_W'(qx_reg);
                mul_b = ftbgf_pkg::B_W'(qz_reg);
            end
            ftbgf_pkg::ST_Q1:
            begin
                mul_a = ftbgf_pkg::A_W'(qw_reg);
                mul_b = ftbgf_pkg::B_W'(qy_reg);
            end
            ftbgf_pkg::ST_Q2:
            begin
                mul_a = ftbgf_pkg::A_W'(qy_reg);
                mul_b = ftbgf_pkg::B_W'(qz_reg);
            end
            ftbgf_pkg::ST_Q3:
            begin
                mul_a = ftbgf_pkg::A_W'(qw_reg);
                mul_b = ftbgf_pkg::B_W'(qx_reg);
            end
            ftbgf_pkg::ST_Q4:
            begin
                mul_a = ftbgf_pkg::A_W'(qw_reg);
                mul_b = ftbgf_pkg::B_W'(qw_reg);
            end
            ftbgf_pkg::ST_Q5:
            begin
                mul_a = ftbgf_pkg::A_W'(qx_reg);
                mul_b = ftbgf_pkg::B_W'(qx_reg);
            end
            ftbgf_pkg::ST_Q6:
            begin
                mul_a = ftbgf_pkg::A_W'(qy_reg);
                mul_b = ftbgf_pkg::B_W'(qy_reg);
            end
            ftbgf_pkg::ST_Q7:
            begin
                mul_a = ftbgf_pkg::A_W'(qz_reg);
                mul_b = ftbgf_pkg::B_W'(qz_reg);
            end
            ftbgf_pkg::ST_F0:
            begin
                mul_a = ftbgf_pkg::A_W'(mg_reg);
                mul_b = r0_reg;
            end
            ftbgf_pkg::ST_F1:
            begin
                mul_a = ftbgf_pkg::A_W'(mg_reg);
                mul_b = r1_reg;
            end
            ftbgf_pkg::ST_F2:
            begin
                mul_a = ftbgf_pkg::A_W'(mg_reg);
                mul_b = r2_reg;
            end
            ftbgf_pkg::ST_T0A:
            begin
                mul_a = ftbgf_pkg::A_W'(ld_reg[2]);
                mul_b = ftbgf_pkg::B_W'(ofs_y_reg);
            end
            ftbgf_pkg::ST_T0B:
            begin
                mul_a = ftbgf_pkg::A_W'(ld_reg[1]);
                mul_b = ftbgf_pkg::B_W'(ofs_z_reg);
            end
            ftbgf_pkg::ST_T1A:
            begin
                mul_a = ftbgf_pkg::A_W'(ld_reg[0]);
                mul_b = ftbgf_pkg::B_W'(ofs_z_reg);
            end
            ftbgf_pkg::ST_T1B:
            begin
                mul_a = ftbgf_pkg::A_W'(ld_reg[2]);
                mul_b = ftbgf_pkg::B_W'(ofs_x_reg);
            end
            ftbgf_pkg::ST_T2A:
            begin
                mul_a = ftbgf_pkg::A_W'(ld_reg[1]);
                mul_b = ftbgf_pkg::B_W'(ofs_x_reg);
            end
            ftbgf_pkg::ST_T2B:
            begin
                mul_a = ftbgf_pkg::A_W'(ld_reg[0]);
                mul_b = ftbgf_pkg::B_W'(ofs_y_reg);
            end
            ftbgf_pkg::ST_FA:
            begin
                mul_a = ftbgf_pkg::A_W'(filt_reg[cmd.lane]);
                mul_b = $signed({5'd0, gain_reg});
            end
            ftbgf_pkg::ST_FB:
            begin
                mul_a = w_lane;
                mul_b = $signed({4'd0, gain_inv});
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        p_reg <= mul_a * mul_b;
        if (cmd.capture)
        begin
            for (int i = 0; i < ftbgf_pkg::LANES; i++)
                raw_reg[i] <= raw_in[i];
            qw_reg <= quat_w;
            qx_reg <= quat_x;
            qy_reg <= quat_y;
            qz_reg <= quat_z;
        end
        // Each step finishes the product issued in the step before it.
        case (cmd.step)
            ftbgf_pkg::ST_Q0: mg_reg <= p_reg[ftbgf_pkg::MG_W-1:0];
            ftbgf_pkg::ST_Q1: t_reg  <= ftbgf_pkg::T_W'(p_reg);
            ftbgf_pkg::ST_Q2: r0_reg <= ftbgf_pkg::R_W'(rnd_shift(sum_sub <<< 1, 14));
            ftbgf_pkg::ST_Q3: t_reg  <= ftbgf_pkg::T_W'(p_reg);
            ftbgf_pkg::ST_Q4: r1_reg <= ftbgf_pkg::R_W'(rnd_shift(sum_add <<< 1, 14));
            ftbgf_pkg::ST_Q5: t_reg  <= ftbgf_pkg::T_W'(p_reg);
            ftbgf_pkg::ST_Q6: t_reg  <= ftbgf_pkg::T_W'(sum_sub);
            ftbgf_pkg::ST_Q7: t_reg  <= ftbgf_pkg::T_W'(sum_sub);
            ftbgf_pkg::ST_F0: r2_reg <= ftbgf_pkg::R_W'(rnd_shift(sum_add, 14));
            ftbgf_pkg::ST_F1: ld_reg[0] <= ftbgf_pkg::LD_W'(-rnd_shift(p_reg, 30));
            ftbgf_pkg::ST_F2: ld_reg[1] <= ftbgf_pkg::LD_W'(-rnd_shift(p_reg, 30));
            ftbgf_pkg::ST_FW: ld_reg[2] <= ftbgf_pkg::LD_W'(-rnd_shift(p_reg, 30));
            ftbgf_pkg::ST_T0B: t_reg <= ftbgf_pkg::T_W'(p_reg);
            ftbgf_pkg::ST_T1A: ld_reg[3] <= ftbgf_pkg::LD_W'(rnd_shift(sum_sub, 12));
            ftbgf_pkg::ST_T1B: t_reg <= ftbgf_pkg::T_W'(p_reg);
            ftbgf_pkg::ST_T2A: ld_reg[4] <= ftbgf_pkg::LD_W'(rnd_shift(sum_sub, 12));
            ftbgf_pkg::ST_T2B: t_reg <= ftbgf_pkg::T_W'(p_reg);
            ftbgf_pkg::ST_TE: ld_reg[5] <= ftbgf_pkg::LD_W'(rnd_shift(sum_sub, 12));
            ftbgf_pkg::ST_FB: t_reg <= ftbgf_pkg::T_W'(p_reg);
            default: ;
        endcase
    end

    // Bias sums and filter state reset to zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ftbgf_pkg::LANES; i++)
            begin
                bias_reg[i] <= '0;
                filt_reg[i] <= '0;
            end
        end
        else
        begin
            case (cmd.step)
                ftbgf_pkg::ST_BIAS:
                begin
                    for (int i = 0; i < ftbgf_pkg::LANES; i++)
                    begin
                        logic signed [34:0] acc;
                        acc = 35'(bias_reg[i]) + 35'(raw_reg[i]) - 35'(ld_reg[i]);
                        if (acc > 35'sh07FFFFFFF)
                            bias_reg[i] <= 32'sh7FFFFFFF;
                        else if (acc < -35'sh080000000)
                            bias_reg[i] <= 32'sh80000000;
                        else
                            bias_reg[i] <= acc[31:0];
                    end
                end
                ftbgf_pkg::ST_AVG:
                begin
                    // Average rounds halves away from zero.
                    for (int i = 0; i < ftbgf_pkg::LANES; i++)
                    begin
                        logic [32:0] mag;
                        logic [32:0] quo;
                        mag = bias_reg[i][31] ? 33'(-34'(bias_reg[i])) : 33'(bias_reg[i]);
                        quo = (mag + 33'(ftbgf_pkg::BIAS_SAMPLES / 2))
                            / 33'(ftbgf_pkg::BIAS_SAMPLES);
                        bias_reg[i] <= bias_reg[i][31] ? -$signed(quo[31:0])
                                                       : $signed(quo[31:0]);
                    end
                end
                ftbgf_pkg::ST_FC:
                begin
                    if (filt_rnd > ftbgf_pkg::P_W'(8388607))
                        filt_reg[cmd.lane] <= 24'sh7FFFFF;
                    else if (filt_rnd < -ftbgf_pkg::P_W'(8388608))
                        filt_reg[cmd.lane] <= 24'sh800000;
                    else
                        filt_reg[cmd.lane] <= filt_rnd[ftbgf_pkg::WR_W-1:0];
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.publish)
        begin
            for (int i = 0; i < ftbgf_pkg::LANES; i++)
                out_filt_reg[i] <= filt_reg[i];
            out_cal_reg <= cmd.calibrated;
        end
    end

    assign filt_out = out_filt_reg;
    assign cal_out  = out_cal_reg;

endmodule
`default_nettype wire

// ===== rtl/core/force_torque_bias_gravity_filter_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// force_torque_bias_gravity_filter_core
// Gravity compensation, bias calibration and low-pass filter for a 6-axis
// force/torque sensor.
//
//   Channel   Handshake            Beat contents
//   input     in_valid/in_ready    raw wrench, quaternion, pose_valid
//   output    out_valid/out_ready  filtered wrench, is_calibrated
//   config    cfg_we               cfg_index, cfg_data (no wait, no read-back)
//
// One input beat at a time: the one shared 36x21 multiplier does every
// product in turn, and a beat without a valid pose goes straight out.
// A finished result sits in the output register, so the next beat is taken
// while it waits. Reset clears the sums, the filter and the calibration.
// ----------------------------------------------------------------------------
module force_torque_bias_gravity_filter_core (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic signed [23:0]                force_x,
    input  wire logic signed [23:0]                force_y,
    input  wire logic signed [23:0]                force_z,
    input  wire logic signed [23:0]                torque_x,
    input  wire logic signed [23:0]                torque_y,
    input  wire logic signed [23:0]                torque_z,
    input  wire logic signed [15:0]                quat_w,
    input  wire logic signed [15:0]                quat_x,
    input  wire logic signed [15:0]                quat_y,
    input  wire logic signed [15:0]                quat_z,
    input  wire logic                              pose_valid,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [23:0]                     filt_force_x,
    output logic signed [23:0]                     filt_force_y,
    output logic signed [23:0]                     filt_force_z,
    output logic signed [23:0]                     filt_torque_x,
    output logic signed [23:0]                     filt_torque_y,
    output logic signed [23:0]                     filt_torque_z,
    output logic                                   is_calibrated,
    input  wire logic                              cfg_we,
    input  wire logic [ftbgf_pkg::CIDX_W-1:0]      cfg_index,
    input  wire logic [ftbgf_pkg::CDAT_W-1:0]      cfg_data
);

    ftbgf_pkg::cmd_t                    cmd;
    logic signed [ftbgf_pkg::WR_W-1:0]  raw_in   [ftbgf_pkg::LANES];
    logic signed [ftbgf_pkg::WR_W-1:0]  filt_out [ftbgf_pkg::LANES];

    assign raw_in[0] = force_x;
    assign raw_in[1] = force_y;
    assign raw_in[2] = force_z;
    assign raw_in[3] = torque_x;
    assign raw_in[4] = torque_y;
    assign raw_in[5] = torque_z;

    ftbgf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .pose_valid (pose_valid),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .cmd        (cmd)
    );

    ftbgf_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .raw_in    (raw_in),
        .quat_w    (quat_w),
        .quat_x    (quat_x),
        .quat_y    (quat_y),
        .quat_z    (quat_z),
        .filt_out  (filt_out),
        .cal_out   (is_calibrated)
    );

    assign filt_force_x  = filt_out[0];
    assign filt_force_y  = filt_out[1];
    assign filt_force_z  = filt_out[2];
    assign filt_torque_x = filt_out[3];
    assign filt_torque_y = filt_out[4];
    assign filt_torque_z = filt_out[5];

`ifndef SYNTHESIS
    // Once calibrated, the block stays calibrated until reset.
    a_calib_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.calibrated |=> cmd.calibrated)
        else $error("calibration flag dropped");

    // After an accepted beat the input is not ready in the following cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again right after accept");

    // Loading the result register always raises the output valid.
    a_publish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |=> out_valid)
        else $error("result loaded without valid");
`endif

endmodule
`default_nettype wire

// ===== test/force_torque_bias_gravity_filter_core_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// force_torque_bias_gravity_filter_core_tb
// Drives raw wrench samples with orientations into the gravity compensation
// filter and checks every filtered wrench and calibration flag against a
// cycle-free predictor of the bias averaging, load model and low-pass filter.
// ----------------------------------------------------------------------------
module force_torque_bias_gravity_filter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  WATCHDOG_LIMIT = 20000;
    localparam int  DRAIN_CYCLES   = 100;
    localparam longint GRAV        = 2632453;
    localparam longint OUT_HI      = 8388607;
    localparam longint OUT_LO      = -8388608;
    localparam longint SUM_HI      = 2147483647;
    localparam longint SUM_LO      = -64'sd2147483648;

    typedef struct {
        logic signed [23:0] wrench[6];
        logic signed [15:0] quat[4];
        logic               pose;
    } sample_t;

    typedef struct {
        logic signed [23:0] wrench[6];
        logic               cal;
    } wrench_out_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [23:0] force_x = '0, force_y = '0, force_z = '0;
    logic signed [23:0] torque_x = '0, torque_y = '0, torque_z = '0;
    logic signed [15:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
    logic pose_valid = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [23:0] filt_force_x, filt_force_y, filt_force_z;
    logic signed [23:0] filt_torque_x, filt_torque_y, filt_torque_z;
    logic is_calibrated;
    logic cfg_we = 1'b0;
    logic [ftbgf_pkg::CIDX_W-1:0] cfg_index = '0;
    logic [ftbgf_pkg::CDAT_W-1:0] cfg_data = '0;

    force_torque_bias_gravity_filter_core dut (.*);

    always #10 clk = ~clk;

    // Predictor state.
    longint gain_q16, mass_g, offs[3];
    longint bias_acc[6], filt_state[6];
    int     summed;
    bit     cal_done;

    sample_t     send_q[$];
    wrench_out_t wrench_expected_q[$];
    int  errors = 0;
    int  quiet_cycles = 0;
    bit  calm = 1'b0;      // no idling on either side while set
    bit  feeding = 1'b0;

    function automatic longint floor_div_pow2(longint v, int sh);
        return v >>> sh;
    endfunction

    function automatic longint rshift_round(longint v, int sh);
        return floor_div_pow2(v + (longint'(1) <<< (sh - 1)), sh);
    endfunction

    function automatic longint sat(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic void predictor_reset();
        gain_q16 = 0; mass_g = 100; offs[0] = 0; offs[1] = 0; offs[2] = 143;
        foreach (bias_acc[i]) begin
            bias_acc[i] = 0;
            filt_state[i] = 0;
        end
        summed = 0;
        cal_done = 1'b0;
    endfunction

    function automatic wrench_out_t predict_wrench(sample_t s);
        wrench_out_t r;
        longint qw, qx, qy, qz, mg, w, acc, mag, q;
        longint rot[3], ld[6];
        qw = s.quat[0]; qx = s.quat[1]; qy = s.quat[2]; qz = s.quat[3];
        if (s.pose) begin
            mg = mass_g * GRAV;
            rot[0] = 2 * (qx * qz - qw * qy);
            rot[1] = 2 * (qy * qz + qw * qx);
            rot[2] = qw * qw - qx * qx - qy * qy + qz * qz;
            for (int i = 0; i < 3; i++)
                ld[i] = -rshift_round(mg * rshift_round(rot[i], 14), 30);
            ld[3] = rshift_round(offs[1] * ld[2] - offs[2] * ld[1], 12);
            ld[4] = rshift_round(offs[2] * ld[0] - offs[0] * ld[2], 12);
            ld[5] = rshift_round(offs[0] * ld[1] - offs[1] * ld[0], 12);
            if (!cal_done) begin
                for (int i = 0; i < 6; i++)
                    bias_acc[i] = sat(bias_acc[i] + s.wrench[i] - ld[i], SUM_LO, SUM_HI);
                summed = (summed + 1) & 127;
                if (summed == ftbgf_pkg::BIAS_SAMPLES) begin
                    for (int i = 0; i < 6; i++) begin
                        mag = bias_acc[i] < 0 ? -bias_acc[i] : bias_acc[i];
                        q = (mag + ftbgf_pkg::BIAS_SAMPLES / 2) / ftbgf_pkg::BIAS_SAMPLES;
                        bias_acc[i] = bias_acc[i] < 0 ? -q : q;
                    end
                    cal_done = 1'b1;
                end
            end
            if (cal_done) begin
                for (int i = 0; i < 6; i++) begin
                    w = s.wrench[i] - bias_acc[i] - ld[i];
                    acc = gain_q16 * filt_state[i] + (65536 - gain_q16) * w;
                    filt_state[i] = sat(rshift_round(acc, 16), OUT_LO, OUT_HI);
                end
            end
        end
        foreach (r.wrench[i]) r.wrench[i] = filt_state[i][23:0];
        r.cal = cal_done;
        return r;
    endfunction

    function automatic logic signed [23:0] rand_wrench_value();
        case ($urandom_range(0, 5))
            0: return 24'sh7FFFFF;
            1: return 24'sh800000;
            2: return 24'($urandom);
            default: return 24'($signed($urandom_range(0, 400000)) - 200000);
        endcase
    endfunction

    function automatic sample_t rand_sample(int pose_pct);
        sample_t s;
        int k;
        foreach (s.wrench[i]) s.wrench[i] = rand_wrench_value();
        k = $urandom_range(0, 9);
        if (k < 6) begin
            // Roughly normalized quaternion: one big component and small others.
            foreach (s.quat[i]) s.quat[i] = 16'($signed($urandom_range(0, 8000)) - 4000);
            s.quat[$urandom_range(0, 3)] = ($urandom_range(0, 1) ? 16'sd16384 : -16'sd16384);
        end else if (k < 8) begin
            foreach (s.quat[i]) s.quat[i] = 16'($urandom);
        end else begin
            foreach (s.quat[i]) s.quat[i] = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        end
        s.pose = $urandom_range(0, 99) < pose_pct;
        return s;
    endfunction

    task automatic cfg_write(ftbgf_pkg::reg_idx_t idx, logic [ftbgf_pkg::CDAT_W-1:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            ftbgf_pkg::REG_FILTER_GAIN:   gain_q16 = longint'(val);
            ftbgf_pkg::REG_LOAD_MASS:     mass_g = longint'(val[11:0]);
            ftbgf_pkg::REG_LOAD_OFFSET_X: offs[0] = longint'($signed(val));
            ftbgf_pkg::REG_LOAD_OFFSET_Y: offs[1] = longint'($signed(val));
            ftbgf_pkg::REG_LOAD_OFFSET_Z: offs[2] = longint'($signed(val));
            default: ;
        endcase
    endtask

    // Queue items, let them drain, then wait out the block's own latency.
    task automatic run_batch(sample_t items[$]);
        send_q = {send_q, items};
        wait (send_q.size() == 0 && !in_valid && wrench_expected_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // A beat is handed over at the rising edge, so predict it there.
    always @(posedge clk) begin
        wrench_out_t p;
        if (in_valid && in_ready) begin
            p = predict_wrench(send_q.pop_front());
            wrench_expected_q = {wrench_expected_q, p};
        end
    end

    logic accepted_last;
    always @(posedge clk) accepted_last <= in_valid && in_ready;

    always @(negedge clk) begin
        sample_t s;
        if (rst_n) begin
            if (!in_valid || accepted_last) begin
                if (send_q.size() != 0 && (calm || $urandom_range(0, 99) >= 30)) begin
                    s = send_q[0];
                    force_x <= s.wrench[0]; force_y <= s.wrench[1]; force_z <= s.wrench[2];
                    torque_x <= s.wrench[3]; torque_y <= s.wrench[4]; torque_z <= s.wrench[5];
                    quat_w <= s.quat[0]; quat_x <= s.quat[1];
                    quat_y <= s.quat[2]; quat_z <= s.quat[3];
                    pose_valid <= s.pose;
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
            out_ready <= calm || $urandom_range(0, 99) >= 30;
        end
    end

    // Monitor.
    always @(posedge clk) begin
        wrench_out_t e;
        logic signed [23:0] got[6];
        if (rst_n && out_valid && out_ready) begin
            got = '{filt_force_x, filt_force_y, filt_force_z,
                    filt_torque_x, filt_torque_y, filt_torque_z};
            if (wrench_expected_q.size() == 0) begin
                $display("%0t: unexpected result beat", $realtime);
                errors++;
            end else begin
                e = wrench_expected_q.pop_front();
                for (int i = 0; i < 6; i++)
                    if (got[i] !== e.wrench[i]) begin
                        $display("%0t: wrench lane %0d expected %0d actual %0d",
                                 $realtime, i, e.wrench[i], got[i]);
                        errors++;
                    end
                if (is_calibrated !== e.cal) begin
                    $display("%0t: is_calibrated expected %0b actual %0b",
                             $realtime, e.cal, is_calibrated);
                    errors++;
                end
            end
        end
    end

    // Watchdog.
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !feeding)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL force_torque_bias_gravity_filter_core");
            $finish;
        end
    end

    initial begin
        sample_t batch[$];
        sample_t s;
        predictor_reset();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        feeding = 1'b1;

        // Directed: extremes, ignored samples, then calibration.
        s = rand_sample(100);
        foreach (s.wrench[i]) s.wrench[i] = 24'sh7FFFFF;
        s.quat = '{16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000};
        batch = {batch, s};
        s.pose = 1'b0;
        batch = {batch, s};
        foreach (s.wrench[i]) s.wrench[i] = 24'sh800000;
        s.pose = 1'b1;
        s.quat = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
        batch = {batch, s};
        s.quat = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0};
        foreach (s.wrench[i]) s.wrench[i] = 24'sd0;
        batch = {batch, s};
        for (int i = 0; i < 20; i++) batch = {batch, rand_sample(80)};
        run_batch(batch);

        cfg_write(ftbgf_pkg::REG_FILTER_GAIN, 16'hFFFF);
        cfg_write(ftbgf_pkg::REG_LOAD_MASS, 16'h0FFF);
        cfg_write(ftbgf_pkg::REG_LOAD_OFFSET_X, 16'h7FFF);
        cfg_write(ftbgf_pkg::REG_LOAD_OFFSET_Y, 16'h8000);
        cfg_write(ftbgf_pkg::REG_LOAD_OFFSET_Z, 16'h7FFF);
        cfg_write(ftbgf_pkg::reg_idx_t'(3'd7), 16'h1234);

        // Finish calibration with a steady stream; the completing beat falls in here.
        for (int phase = 0; phase < 6; phase++) begin
            batch.delete();
            calm = (phase == 2);
            for (int i = 0; i < 300; i++) batch = {batch, rand_sample(85)};
            run_batch(batch);
            case (phase)
                0: begin
                    cfg_write(ftbgf_pkg::REG_FILTER_GAIN, 16'h0000);
                    cfg_write(ftbgf_pkg::REG_LOAD_MASS, 16'h0000);
                end
                1: begin
                    cfg_write(ftbgf_pkg::REG_FILTER_GAIN, 16'($urandom));
                    cfg_write(ftbgf_pkg::REG_LOAD_MASS, 16'($urandom_range(0, 4095)));
                    cfg_write(ftbgf_pkg::REG_LOAD_OFFSET_X, 16'h8000);
                    cfg_write(ftbgf_pkg::REG_LOAD_OFFSET_Y, 16'h7FFF);
                    cfg_write(ftbgf_pkg::REG_LOAD_OFFSET_Z, 16'h8000);
                end
                default: begin
                    cfg_write(ftbgf_pkg::REG_FILTER_GAIN, 16'($urandom));
                    cfg_write(ftbgf_pkg::REG_LOAD_MASS, 16'($urandom_range(0, 4095)));
                    cfg_write(ftbgf_pkg::REG_LOAD_OFFSET_X, 16'($urandom));
                    cfg_write(ftbgf_pkg::REG_LOAD_OFFSET_Y, 16'($urandom));
                    cfg_write(ftbgf_pkg::REG_LOAD_OFFSET_Z, 16'($urandom));
                end
            endcase
        end
        calm = 1'b0;
        feeding = 1'b0;

        if (errors == 0)
            $display("PASS force_torque_bias_gravity_filter_core");
        else
            $display("FAIL force_torque_bias_gravity_filter_core");
        $finish;
    end

endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/core/ftbgf_pkg.sv
rtl/core/ftbgf_ctrl.sv
rtl/core/ftbgf_dp.sv
rtl/core/force_torque_bias_gravity_filter_core.sv
test/force_torque_bias_gravity_filter_core_tb.sv
